>>> rtl/thc_pkg.sv
// shared types and constants for the temperature and humidity compensation block
package thc_pkg;

  localparam int RAW_T_W = 20;
  localparam int RAW_H_W = 16;
  localparam int TEMP_W  = 15;
  localparam int MILLI_W = 17;
  localparam int CLIP_W  = 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // pipeline depth of each section
  localparam int TEMP_STAGES = 5;
  localparam int HUM_STAGES  = 17;
  localparam int NUM_STAGES  = TEMP_STAGES + HUM_STAGES;

  typedef enum logic [2:0] {
    REG_TEMP_OFFSET    = 3'd0,
    REG_TEMP_SLOPE     = 3'd1,
    REG_TEMP_CURVE     = 3'd2,
    REG_HUM_OFFSET     = 3'd3,
    REG_HUM_GAIN       = 3'd4,
    REG_HUM_TEMP_TERMS = 3'd5,
    REG_HUM_SQUARE     = 3'd6,
    REG_HUM_SQUARE_T   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLIP_NONE = 2'd0,
    CLIP_HIGH = 2'd1,
    CLIP_LOW  = 2'd2
  } clip_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [7:0]  t3;
    logic [11:0] h1;
    logic [11:0] h2;
    logic [23:0] h345;
    logic [7:0]  h6;
    logic [7:0]  h7;
  } cal_t;

  localparam logic signed [14:0] TEMP_MIN  = -15'sd4000;
  localparam logic signed [14:0] TEMP_MAX  = 15'sd8500;
  localparam logic [16:0]        MILLI_MAX = 17'd100000;

  // 2^37, rounding half up before the shift by 38
  localparam logic signed [56:0] TEMP_ROUND = 57'sd137438953472;
  // 2^20 * 10^4
  localparam logic signed [35:0] K_BASE     = 36'sd10485760000;

  // floor division by 128000000 = 2^13 * 15625
  localparam logic [26:0] DIV_A_BIAS = 27'd127999999;
  localparam logic [28:0] DIV_A_M    = 29'd281474976;
  localparam logic [13:0] DIV_A_D    = 14'd15625;
  localparam logic [15:0] DIV_A_D1   = 16'd15625;
  localparam logic [15:0] DIV_A_D2   = 16'd31250;

  // floor division by 209715200 = 2^23 * 25
  localparam logic [4:0]  DIV_B_BIAS  = 5'd24;
  localparam logic [27:0] DIV_B_M     = 28'd171798691;
  localparam logic [4:0]  DIV_B_D     = 5'd25;
  localparam logic [12:0] DIV_B_RECIP = 13'd5243;

endpackage

>>> rtl/thc_if.sv
// input and result channel interfaces
interface thc_in_if;
  logic                        valid;
  logic                        ready;
  logic [thc_pkg::RAW_T_W-1:0] raw_temperature;
  logic [thc_pkg::RAW_H_W-1:0] raw_humidity;
  modport source (output valid, output raw_temperature, output raw_humidity, input ready);
  modport sink (input valid, input raw_temperature, input raw_humidity, output ready);
endinterface

interface thc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [thc_pkg::TEMP_W-1:0]  temperature_centi;
  logic        [thc_pkg::MILLI_W-1:0] humidity_milli;
  logic        [thc_pkg::CLIP_W-1:0]  hum_clipped;
  modport source (output valid, output temperature_centi, output humidity_milli,
                  output hum_clipped, input ready);
  modport sink (input valid, input temperature_centi, input humidity_milli,
                input hum_clipped, output ready);
endinterface

>>> rtl/temp_humidity_compensation.sv
// top level of the temperature and humidity compensation block
//
// in_if carries one raw 20-bit temperature and one raw 16-bit humidity reading
// per item; out_if returns the compensated temperature in 0.01 C (saturated to
// -40..85 C), the relative humidity in 0.001 % (clamped to 0..100 %) and a code
// telling whether the humidity was clamped high or low.
// calibration words are written through the apb-style port (psel, penable,
// pwrite, paddr, pwdata); register i sits at byte address 4*i, reads return it.
// write them only while no item is in flight.
// there are 22 register stages: 5 of temperature polynomial, then 17 of
// humidity polynomial including two constant dividers built from reciprocal
// multiplies with remainder correction.
// throughput is one item per cycle; every stage has its own valid bit, so a
// stalled receiver only holds the result register and bubbles behind it close
// up before in_if.ready drops.
// reset clears the valid bits and all calibration registers to zero; there is
// no state carried between items.
module temp_humidity_compensation (
  input  logic                        clk,
  input  logic                        rst_n,
  thc_in_if.sink                      in_if,
  thc_out_if.source                   out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [thc_pkg::ADDR_W-1:0]  paddr,
  input  logic [thc_pkg::DATA_W-1:0]  pwdata,
  output logic [thc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int NS = thc_pkg::NUM_STAGES;
  localparam int TS = thc_pkg::TEMP_STAGES;

  thc_pkg::cal_t                     cal;
  logic [NS:0]                       en;
  logic [NS-1:0]                     v_r, v_nxt;
  logic signed [thc_pkg::TEMP_W-1:0] temp_mid;
  logic [thc_pkg::RAW_H_W-1:0]       hum_mid;
  thc_pkg::clip_t                    clip;

  thc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal     (cal)
  );

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[NS] = out_if.ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt[0] = en[0] ? in_if.valid : v_r[0];
    for (int i = 1; i < NS; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_if.ready  = en[0];
  assign out_if.valid = v_r[NS-1];

  thc_temp u_temp (
    .clk             (clk),
    .en              (en[TS-1:0]),
    .raw_temperature (in_if.raw_temperature),
    .raw_humidity    (in_if.raw_humidity),
    .cal             (cal),
    .temperature     (temp_mid),
    .humidity_raw    (hum_mid)
  );

  thc_hum u_hum (
    .clk               (clk),
    .en                (en[NS-1:TS]),
    .temperature       (temp_mid),
    .humidity_raw      (hum_mid),
    .cal               (cal),
    .temperature_centi (out_if.temperature_centi),
    .humidity_milli    (out_if.humidity_milli),
    .hum_clipped       (clip)
  );

  assign out_if.hum_clipped = clip;

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.temperature_centi >= thc_pkg::TEMP_MIN &&
                      out_if.temperature_centi <= thc_pkg::TEMP_MAX))
    else $error("temperature outside saturation range");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.humidity_milli <= thc_pkg::MILLI_MAX)
    else $error("humidity above clamp");

  a_clip_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.hum_clipped == thc_pkg::CLIP_HIGH
      |-> out_if.humidity_milli == thc_pkg::MILLI_MAX)
    else $error("high clamp code without full scale humidity");

  a_clip_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.hum_clipped == thc_pkg::CLIP_LOW
      |-> out_if.humidity_milli == '0)
    else $error("low clamp code without zero humidity");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> out_if.valid && !out_if.ready)
    else $error("input stalled while output not blocked");

endmodule

>>> rtl/thc_regs.sv
// calibration register file behind the apb-style port
module thc_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [thc_pkg::ADDR_W-1:0]  paddr,
  input  logic [thc_pkg::DATA_W-1:0]  pwdata,
  output logic [thc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output thc_pkg::cal_t               cal
);

  thc_pkg::cal_t     cal_r;
  thc_pkg::reg_idx_t idx;

  assign idx    = thc_pkg::reg_idx_t'(paddr[thc_pkg::ADDR_W-1:2]);
  assign pready = 1'b1;
  assign cal    = cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        thc_pkg::REG_TEMP_OFFSET:    cal_r.t1   <= pwdata[15:0];
        thc_pkg::REG_TEMP_SLOPE:     cal_r.t2   <= pwdata[15:0];
        thc_pkg::REG_TEMP_CURVE:     cal_r.t3   <= pwdata[7:0];
        thc_pkg::REG_HUM_OFFSET:     cal_r.h1   <= pwdata[11:0];
        thc_pkg::REG_HUM_GAIN:       cal_r.h2   <= pwdata[11:0];
        thc_pkg::REG_HUM_TEMP_TERMS: cal_r.h345 <= pwdata[23:0];
        thc_pkg::REG_HUM_SQUARE:     cal_r.h6   <= pwdata[7:0];
        thc_pkg::REG_HUM_SQUARE_T:   cal_r.h7   <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      thc_pkg::REG_TEMP_OFFSET:    prdata = 32'(cal_r.t1);
      thc_pkg::REG_TEMP_SLOPE:     prdata = 32'(cal_r.t2);
      thc_pkg::REG_TEMP_CURVE:     prdata = 32'(cal_r.t3);
      thc_pkg::REG_HUM_OFFSET:     prdata = 32'(cal_r.h1);
      thc_pkg::REG_HUM_GAIN:       prdata = 32'(cal_r.h2);
      thc_pkg::REG_HUM_TEMP_TERMS: prdata = 32'(cal_r.h345);
      thc_pkg::REG_HUM_SQUARE:     prdata = 32'(cal_r.h6);
      thc_pkg::REG_HUM_SQUARE_T:   prdata = 32'(cal_r.h7);
    endcase
  end

endmodule

>>> rtl/thc_temp.sv
// temperature compensation pipeline, five stages
module thc_temp (
  input  logic                                clk,
  input  logic [thc_pkg::TEMP_STAGES-1:0]     en,
  input  logic [thc_pkg::RAW_T_W-1:0]         raw_temperature,
  input  logic [thc_pkg::RAW_H_W-1:0]         raw_humidity,
  input  thc_pkg::cal_t                       cal,
  output logic signed [thc_pkg::TEMP_W-1:0]   temperature,
  output logic [thc_pkg::RAW_H_W-1:0]         humidity_raw
);

  localparam logic signed [18:0] TMIN19 = 19'(thc_pkg::TEMP_MIN);
  localparam logic signed [18:0] TMAX19 = 19'(thc_pkg::TEMP_MAX);

  logic signed [20:0] d_r, d_nxt;
  logic signed [36:0] lin_r, lin_nxt, lin2_r;
  logic [40:0]        sq_r;
  logic signed [41:0] sq_full;
  logic signed [47:0] cub_r, cub_nxt;
  logic signed [53:0] n_r, n_nxt;
  logic signed [56:0] n5;
  logic signed [18:0] tf;
  logic signed [14:0] temp_r, temp_nxt;
  logic [thc_pkg::RAW_H_W-1:0] h_r [thc_pkg::TEMP_STAGES];

  always_comb begin
    d_nxt   = 21'($signed({2'b00, raw_temperature}) - $signed({2'b00, cal.t1, 4'b0000}));
    lin_nxt = 37'(d_r) * 37'($signed(cal.t2));
    sq_full = 42'(d_r) * 42'(d_r);
    cub_nxt = 48'($signed({1'b0, sq_r})) * 48'($signed(cal.t3));
    n_nxt   = (54'(lin2_r) <<< 16) + 54'(cub_r);
    // times five, round half up, divide by 2^38
    n5      = (57'(n_r) <<< 2) + 57'(n_r) + thc_pkg::TEMP_ROUND;
    tf      = n5[56:38];
    if (tf < TMIN19) begin
      temp_nxt = thc_pkg::TEMP_MIN;
    end else if (tf > TMAX19) begin
      temp_nxt = thc_pkg::TEMP_MAX;
    end else begin
      temp_nxt = tf[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_r    <= d_nxt;
      h_r[0] <= raw_humidity;
    end
    if (en[1]) begin
      lin_r <= lin_nxt;
      sq_r  <= sq_full[40:0];
    end
    if (en[2]) begin
      cub_r  <= cub_nxt;
      lin2_r <= lin_r;
    end
    if (en[3]) begin
      n_r <= n_nxt;
    end
    if (en[4]) begin
      temp_r <= temp_nxt;
    end
    for (int i = 1; i < thc_pkg::TEMP_STAGES; i++) begin
      if (en[i]) begin
        h_r[i] <= h_r[i-1];
      end
    end
  end

  assign temperature  = temp_r;
  assign humidity_raw = h_r[thc_pkg::TEMP_STAGES-1];

endmodule

>>> rtl/thc_hum.sv
// humidity compensation pipeline, seventeen stages with two constant dividers
module thc_hum (
  input  logic                               clk,
  input  logic [thc_pkg::HUM_STAGES-1:0]     en,
  input  logic signed [thc_pkg::TEMP_W-1:0]  temperature,
  input  logic [thc_pkg::RAW_H_W-1:0]        humidity_raw,
  input  thc_pkg::cal_t                      cal,
  output logic signed [thc_pkg::TEMP_W-1:0]  temperature_centi,
  output logic [thc_pkg::MILLI_W-1:0]        humidity_milli,
  output thc_pkg::clip_t                     hum_clipped
);

  // stage 0
  logic signed [25:0] v1_r [3];
  logic signed [25:0] v1_nxt;
  logic [26:0]        tt_r;
  logic signed [29:0] tt_full;
  logic signed [21:0] h4t_r, h4t_nxt;
  logic signed [23:0] cn_r [9];
  logic signed [23:0] cn_nxt;
  // stages 1 to 3
  logic signed [35:0] k_r, k_nxt;
  logic signed [47:0] hk_r;
  logic signed [48:0] hk_full;
  logic signed [55:0] p_r;
  logic signed [57:0] p_full;
  // stages 4 to 7, floor division by 128000000
  logic [55:0]        ua;
  logic [41:0]        x_r, x2_r;
  logic               nega_r [3];
  logic [60:0]        qa_full;
  logic [28:0]        q0_r, q0b_r;
  logic [42:0]        qd;
  logic [41:0]        ra;
  logic [15:0]        r_r;
  logic [28:0]        qa;
  logic signed [29:0] v2_r [7];
  logic signed [29:0] v2_nxt;
  // stages 8 to 10
  logic signed [59:0] vv;
  logic [41:0]        sq_r;
  logic signed [45:0] pl_r, pl_nxt, ph_r, ph_nxt;
  logic signed [66:0] cp_full;
  logic signed [63:0] cp_r;
  // stages 11 to 14, floor division by 209715200
  logic [40:0]        ub;
  logic [40:0]        u2_r, u2b_r;
  logic               negb_r [3];
  logic [59:0]        qb_full;
  logic [36:0]        qb0_r, qb0b_r;
  logic [41:0]        qm;
  logic [40:0]        rb;
  logic [13:0]        r2_r;
  logic [26:0]        cf;
  logic [36:0]        qb;
  logic signed [37:0] hd;
  logic signed [38:0] h_r, h_nxt;
  // stages 15 and 16
  logic signed [48:0] hm_r, hm_nxt;
  logic signed [32:0] mw;
  logic [16:0]        milli_r, milli_nxt;
  thc_pkg::clip_t     clip_r, clip_nxt;
  logic signed [thc_pkg::TEMP_W-1:0] tc_r [thc_pkg::HUM_STAGES];

  always_comb begin
    v1_nxt  = 26'($signed({1'b0, humidity_raw})) * 26'sd200
            - 26'($signed({1'b0, cal.h1})) * 26'sd3200
            - 26'($signed(cal.h345[7:0])) * 26'(temperature);
    tt_full = 30'(temperature) * 30'(temperature);
    h4t_nxt = 22'($signed(cal.h345[15:8])) * 22'(temperature);
    cn_nxt  = 24'($signed({1'b0, cal.h6})) * 24'sd12800
            + 24'($signed(cal.h7)) * 24'(temperature);

    k_nxt   = thc_pkg::K_BASE + 36'(h4t_r) * 36'sd6400
            + 36'($signed(cal.h345[23:16])) * 36'($signed({1'b0, tt_r}));
    hk_full = 49'($signed({1'b0, cal.h2})) * 49'(k_r);
    p_full  = 58'(v1_r[2]) * 58'($signed(hk_r[47:16]));

    // negative dividend: floor(p/d) = -floor((d-1-p)/d)
    ua      = p_r[55] ? (56'(thc_pkg::DIV_A_BIAS) - $unsigned(p_r)) : $unsigned(p_r);
    qa_full = 61'(x_r[41:10]) * 61'(thc_pkg::DIV_A_M);
    qd      = 43'(q0_r) * 43'(thc_pkg::DIV_A_D);
    ra      = x2_r - qd[41:0];
    // estimate is low by at most two
    qa      = q0b_r + 29'(r_r >= thc_pkg::DIV_A_D1) + 29'(r_r >= thc_pkg::DIV_A_D2);
    v2_nxt  = nega_r[2] ? -$signed({1'b0, qa}) : $signed({1'b0, qa});

    vv      = 60'(v2_r[0]) * 60'(v2_r[0]);
    pl_nxt  = 46'(cn_r[8]) * 46'($signed({1'b0, sq_r[20:0]}));
    ph_nxt  = 46'(cn_r[8]) * 46'($signed({1'b0, sq_r[41:21]}));
    cp_full = (67'(ph_r) <<< 21) + 67'(pl_r);

    ub      = cp_r[63] ? (41'(thc_pkg::DIV_B_BIAS) - $unsigned(cp_r[63:23]))
                       : $unsigned(cp_r[63:23]);
    qb_full = 60'(u2_r[40:9]) * 60'(thc_pkg::DIV_B_M);
    qm      = 42'(qb0_r) * 42'(thc_pkg::DIV_B_D);
    rb      = u2b_r - qm[40:0];
    // small remainder correction by reciprocal
    cf      = 27'(r2_r) * 27'(thc_pkg::DIV_B_RECIP);
    qb      = qb0b_r + 37'(cf[26:17]);
    hd      = negb_r[2] ? -$signed({1'b0, qb}) : $signed({1'b0, qb});
    h_nxt   = 39'(v2_r[6]) + 39'(hd);

    hm_nxt  = 49'(h_r) * 49'sd1000 + 49'sd32768;
    mw      = hm_r[48:16];
    if (mw > $signed({16'b0, thc_pkg::MILLI_MAX})) begin
      milli_nxt = thc_pkg::MILLI_MAX;
      clip_nxt  = thc_pkg::CLIP_HIGH;
    end else if (mw < 33'sd0) begin
      milli_nxt = '0;
      clip_nxt  = thc_pkg::CLIP_LOW;
    end else begin
      milli_nxt = mw[16:0];
      clip_nxt  = thc_pkg::CLIP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      v1_r[0] <= v1_nxt;
      tt_r    <= tt_full[26:0];
      h4t_r   <= h4t_nxt;
      cn_r[0] <= cn_nxt;
    end
    if (en[1]) begin
      k_r     <= k_nxt;
      v1_r[1] <= v1_r[0];
    end
    if (en[2]) begin
      hk_r    <= hk_full[47:0];
      v1_r[2] <= v1_r[1];
    end
    if (en[3]) begin
      p_r <= p_full[55:0];
    end
    if (en[4]) begin
      x_r       <= ua[54:13];
      nega_r[0] <= p_r[55];
    end
    if (en[5]) begin
      q0_r      <= qa_full[60:32];
      x2_r      <= x_r;
      nega_r[1] <= nega_r[0];
    end
    if (en[6]) begin
      r_r       <= ra[15:0];
      q0b_r     <= q0_r;
      nega_r[2] <= nega_r[1];
    end
    if (en[7]) begin
      v2_r[0] <= v2_nxt;
    end
    if (en[8]) begin
      sq_r <= vv[57:16];
    end
    if (en[9]) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
    end
    if (en[10]) begin
      cp_r <= cp_full[63:0];
    end
    if (en[11]) begin
      u2_r      <= ub;
      negb_r[0] <= cp_r[63];
    end
    if (en[12]) begin
      qb0_r     <= qb_full[59:23];
      u2b_r     <= u2_r;
      negb_r[1] <= negb_r[0];
    end
    if (en[13]) begin
      r2_r      <= rb[13:0];
      qb0b_r    <= qb0_r;
      negb_r[2] <= negb_r[1];
    end
    if (en[14]) begin
      h_r <= h_nxt;
    end
    if (en[15]) begin
      hm_r <= hm_nxt;
    end
    if (en[16]) begin
      milli_r <= milli_nxt;
      clip_r  <= clip_nxt;
    end
    for (int i = 1; i < 9; i++) begin
      if (en[i]) begin
        cn_r[i] <= cn_r[i-1];
      end
    end
    for (int i = 1; i < 7; i++) begin
      if (en[i+7]) begin
        v2_r[i] <= v2_r[i-1];
      end
    end
    if (en[0]) begin
      tc_r[0] <= temperature;
    end
    for (int i = 1; i < thc_pkg::HUM_STAGES; i++) begin
      if (en[i]) begin
        tc_r[i] <= tc_r[i-1];
      end
    end
  end

  assign temperature_centi = tc_r[thc_pkg::HUM_STAGES-1];
  assign humidity_milli    = milli_r;
  assign hum_clipped       = clip_r;

endmodule
